[sv/tea_block_cipher_macros.svh]
// Assertion macros shared by the tea_block_cipher checker.
// Needs a clk and rst signal in the scope where a macro is used.
`ifndef TEA_BLOCK_CIPHER_MACROS_SVH
`define TEA_BLOCK_CIPHER_MACROS_SVH

// Same-cycle implication, off while reset is high
`define TEA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is high
`define TEA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/tea_pkg.sv]
// Shared types, constants and the round mix function for the TEA cipher.
// No dependencies.
package tea_pkg;

  localparam int unsigned WORD_W = 32;
  localparam logic [WORD_W-1:0] TEA_DELTA = 32'h3de6e675;

  // Key register indexes on the config port
  localparam logic [1:0] KEY_IDX_ZERO  = 2'd0;
  localparam logic [1:0] KEY_IDX_ONE   = 2'd1;
  localparam logic [1:0] KEY_IDX_TWO   = 2'd2;
  localparam logic [1:0] KEY_IDX_THREE = 2'd3;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    word_t k0;
    word_t k1;
    word_t k2;
    word_t k3;
  } key_t;

  // One pipeline slot: valid, mode and the two block halves
  typedef struct packed {
    logic  valid;
    logic  mode;
    word_t y;
    word_t z;
  } stg_t;

  // TEA F function
  function automatic word_t tea_mix(input word_t w, input word_t s,
                                    input word_t kl, input word_t kr);
    return ((w << 4) + kl) ^ (w + s) ^ ((w >> 5) + kr);
  endfunction

endpackage

[sv/tea_round.sv]
// One Feistel round of the TEA pipeline, split into two registered half rounds.
// Depends on tea_pkg.
module tea_round import tea_pkg::*; #(
  parameter logic [31:0] SUM_ENC = 32'h0,
  parameter logic [31:0] SUM_DEC = 32'h0
) (
  input  logic clk,
  input  logic rst,
  input  logic advance,
  input  key_t key,
  input  stg_t din,
  output stg_t dout
);

  stg_t  mid;
  stg_t  mid_next;
  stg_t  dout_next;
  word_t sum_a;
  word_t sum_b;
  word_t mix_a;
  word_t mix_b;

  // Round sum depends on direction
  assign sum_a = din.mode ? SUM_DEC : SUM_ENC;
  assign sum_b = mid.mode ? SUM_DEC : SUM_ENC;

  // First half: encrypt updates y from z, decrypt updates z from y
  always_comb begin
    mix_a = din.mode ? tea_mix(din.y, sum_a, key.k2, key.k3)
                     : tea_mix(din.z, sum_a, key.k0, key.k1);
    mid_next = din;
    if (din.mode) begin
      mid_next.z = din.z - mix_a;
    end else begin
      mid_next.y = din.y + mix_a;
    end
  end

  // Second half: encrypt updates z from new y, decrypt updates y from new z
  always_comb begin
    mix_b = mid.mode ? tea_mix(mid.z, sum_b, key.k0, key.k1)
                     : tea_mix(mid.y, sum_b, key.k2, key.k3);
    dout_next = mid;
    if (mid.mode) begin
      dout_next.y = mid.y - mix_b;
    end else begin
      dout_next.z = mid.z + mix_b;
    end
  end

  // Stage registers; reset clears only the valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      mid.valid  <= 1'b0;
      dout.valid <= 1'b0;
    end else if (advance) begin
      mid  <= mid_next;
      dout <= dout_next;
    end
  end

endmodule

[sv/tea_block_cipher.sv]
// TEA block cipher: top level with key registers and the unrolled round pipeline.
// Depends on tea_pkg and tea_round.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one 64-bit block per beat as
//   first_word/second_word plus mode (0 encrypt, 1 decrypt).
//   Output channel (out_valid/out_ready) returns the transformed block.
//   Keys are written through cfg_wr_en/cfg_index/cfg_data, one 32-bit word
//   per write; the user must write them only while no block is in flight,
//   as the block itself does not enforce this.
// Pipeline: 2*ROUNDS register stages. Each round is two register stages,
//   one per half round adder chain.
// Throughput: one block per cycle while out_ready is high.
// Stall: the whole pipeline holds while the last stage has a result and
//   out_ready is low; in_ready is low only then and during reset. Empty
//   slots keep moving, so new blocks are taken while the output stage is empty.
// Reset: rst clears all stage valid bits and sets the four key words to 0.
module tea_block_cipher import tea_pkg::*; #(
  parameter int ROUNDS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [31:0] first_word,
  input  logic [31:0] second_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] first_word_out,
  output logic [31:0] second_word_out,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  key_t key;
  stg_t stage [ROUNDS+1];
  logic advance;

  // Key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        KEY_IDX_ZERO:  key.k0 <= cfg_data;
        KEY_IDX_ONE:   key.k1 <= cfg_data;
        KEY_IDX_TWO:   key.k2 <= cfg_data;
        KEY_IDX_THREE: key.k3 <= cfg_data;
        default: ;
      endcase
    end
  end

  // Global advance: move unless a finished result is held back
  assign advance  = ~stage[ROUNDS].valid | out_ready;
  assign in_ready = advance & ~rst;

  // Pipeline input slot
  assign stage[0] = {in_valid, mode, first_word, second_word};

  // Unrolled rounds with per-round sum constants
  for (genvar r = 0; r < ROUNDS; r++) begin : g_round
    localparam logic [63:0] ENC_P = 64'(TEA_DELTA) * 64'(r + 1);
    localparam logic [63:0] DEC_P = 64'(TEA_DELTA) * 64'(ROUNDS - r);
    tea_round #(
      .SUM_ENC (ENC_P[31:0]),
      .SUM_DEC (DEC_P[31:0])
    ) u_round (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .key     (key),
      .din     (stage[r]),
      .dout    (stage[r+1])
    );
  end

  // Output beat
  assign out_valid       = stage[ROUNDS].valid;
  assign first_word_out  = stage[ROUNDS].y;
  assign second_word_out = stage[ROUNDS].z;

endmodule

[sv/tea_chk.sv]
// Port-level checker for tea_block_cipher, attached by bind.
// Depends on tea_block_cipher_macros.svh.
`include "tea_block_cipher_macros.svh"

module tea_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] first_word_out,
  input logic [31:0] second_word_out
);

  // A stalled result beat holds its value
  `TEA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(first_word_out) && $stable(second_word_out),
    "output beat changed while stalled")

  // Input side never stalls while the output side takes beats
  `TEA_ASSERT_NOW(a_ready_follows, out_ready, in_ready,
    "in_ready low while out_ready high")

  // Input side never stalls while no result waits
  `TEA_ASSERT_NOW(a_ready_empty, !out_valid, in_ready,
    "in_ready low with no result pending")

  // A stall at the output blocks the input in that same cycle
  `TEA_ASSERT_NOW(a_stall_blocks, out_valid && !out_ready, !in_ready,
    "input taken while output stalled")

endmodule

bind tea_block_cipher tea_chk u_chk (.*);
